// ----- hdl/dgr_pkg.sv -----
`timescale 1ns / 1ps
package dgr_pkg;

   localparam logic [1:0] CMD_WRITE_TILE = 2'd0;
   localparam logic [1:0] CMD_CAST       = 2'd1;
   localparam logic [1:0] CMD_READ_DEPTH = 2'd2;
   localparam logic [1:0] CMD_UNUSED     = 2'd3;

   localparam logic [2:0] REG_CAM_X         = 3'd0;
   localparam logic [2:0] REG_CAM_Y         = 3'd1;
   localparam logic [2:0] REG_CAM_ANGLE     = 3'd2;
   localparam logic [2:0] REG_FOV           = 3'd3;
   localparam logic [2:0] REG_ANGLE_STEP    = 3'd4;
   localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd5;
   localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd6;
   localparam logic [2:0] REG_TILE_SIZE     = 3'd7;

   localparam logic [23:0] DIST_MAX = 24'hFFFFFF;

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE, ST_TILE, ST_DRD, ST_DOUT, ST_NOP, ST_ANGLE, ST_TRIG_X,
      ST_TRIG_Y, ST_DIVX, ST_DIVX_W, ST_DIVY, ST_DIVY_W, ST_SIDE, ST_STEP,
      ST_TRD, ST_CHK, ST_MISS, ST_MULP_I, ST_MULP, ST_TRIG_C, ST_MULD_I,
      ST_MULD, ST_DSAT, ST_DIVH, ST_DIVH_W, ST_HIT_OUT
   } dgr_state_type;

   typedef enum logic [4:0] {
      OP_IDLE, OP_CLEAR, OP_LOAD, OP_TILE, OP_DRD, OP_DOUT, OP_NOP, OP_ANGLE,
      OP_TRIG_X, OP_TRIG_Y, OP_DIV_X, OP_WAIT_X, OP_DIV_Y, OP_WAIT_Y, OP_SIDE,
      OP_STEP, OP_TRD, OP_CHK, OP_MISS, OP_MUL_INIT_P, OP_MUL, OP_TRIG_C,
      OP_MUL_INIT_D, OP_DSAT, OP_DIV_H, OP_WAIT_H, OP_HIT_OUT
   } dgr_op_type;

   typedef struct packed {
      dgr_op_type op;
   } dgr_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic div_done;
      logic hit;
      logic steps_done;
      logic mul_last;
   } dgr_status_type;

   // quarter-wave sine entry, Q1.14
   function automatic logic [14:0] quarter_sine(input int unsigned k,
                                                input int unsigned tb);
      longint t;
      longint x2;
      longint acc;
      longint r;
      longint q;
      if (k >= (32'd1 << (tb - 2))) begin
         return 15'd16384;
      end
      t   = longint'(k) << (18 - tb);
      x2  = (t * t) / 65536;
      acc = 2692;
      acc = -78547 + (acc * x2) / 65536;
      acc = 1337020 + (acc * x2) / 65536;
      acc = -10837479 + (acc * x2) / 65536;
      acc = 26353589 + (acc * x2) / 65536;
      r   = (acc * t) / 65536;
      if (r < 0) begin
         r = 0;
      end
      q = (r + 512) / 1024;
      if (q > 16384) begin
         q = 16384;
      end
      return 15'(q);
   endfunction

endpackage

// ----- hdl/dgr_div.sv -----
`timescale 1ns / 1ps
module dgr_div #(
   parameter int N = 32,
   parameter int D = 24
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [N-1:0] dividend,
   input  logic [D-1:0] divisor,
   output logic         done,
   output logic [N-1:0] quotient
);
   localparam int CW = $clog2(N + 1);

   logic [N-1:0]  q_ff, q_in;
   logic [D-1:0]  rem_ff, rem_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          done_ff, done_in;
   logic [D:0]    trial;

   always_comb begin
      trial   = {rem_ff, q_ff[N-1]};
      q_in    = q_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         q_in   = dividend;
         rem_in = '0;
         cnt_in = CW'(N);
      end else if (cnt_ff != '0) begin
         if (trial >= {1'b0, divisor}) begin
            rem_in = D'(trial - {1'b0, divisor});
            q_in   = {q_ff[N-2:0], 1'b1};
         end else begin
            rem_in = trial[D-1:0];
            q_in   = {q_ff[N-2:0], 1'b0};
         end
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      q_ff   <= q_in;
      rem_ff <= rem_in;
   end

   assign done     = done_ff;
   assign quotient = q_ff;
endmodule

// ----- hdl/dgr_ctrl.sv -----
`timescale 1ns / 1ps
module dgr_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [1:0]             req_command,
   input  dgr_pkg::dgr_status_type status,
   output dgr_pkg::dgr_cmd_type    cmd,
   output logic                   busy
);
   dgr_pkg::dgr_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dgr_pkg::ST_CLEAR:   if (status.clr_last) state_in = dgr_pkg::ST_IDLE;
         dgr_pkg::ST_IDLE: begin
            if (start) begin
               case (req_command)
                  dgr_pkg::CMD_WRITE_TILE: state_in = dgr_pkg::ST_TILE;
                  dgr_pkg::CMD_CAST:       state_in = dgr_pkg::ST_ANGLE;
                  dgr_pkg::CMD_READ_DEPTH: state_in = dgr_pkg::ST_DRD;
                  default:                 state_in = dgr_pkg::ST_NOP;
               endcase
            end
         end
         dgr_pkg::ST_TILE:    state_in = dgr_pkg::ST_IDLE;
         dgr_pkg::ST_NOP:     state_in = dgr_pkg::ST_IDLE;
         dgr_pkg::ST_DOUT:    state_in = dgr_pkg::ST_IDLE;
         dgr_pkg::ST_MISS:    state_in = dgr_pkg::ST_IDLE;
         dgr_pkg::ST_HIT_OUT: state_in = dgr_pkg::ST_IDLE;
         dgr_pkg::ST_DRD:     state_in = dgr_pkg::ST_DOUT;
         dgr_pkg::ST_ANGLE:   state_in = dgr_pkg::ST_TRIG_X;
         dgr_pkg::ST_TRIG_X:  state_in = dgr_pkg::ST_TRIG_Y;
         dgr_pkg::ST_TRIG_Y:  state_in = dgr_pkg::ST_DIVX;
         dgr_pkg::ST_DIVX:    state_in = dgr_pkg::ST_DIVX_W;
         dgr_pkg::ST_DIVX_W:  if (status.div_done) state_in = dgr_pkg::ST_DIVY;
         dgr_pkg::ST_DIVY:    state_in = dgr_pkg::ST_DIVY_W;
         dgr_pkg::ST_DIVY_W:  if (status.div_done) state_in = dgr_pkg::ST_SIDE;
         dgr_pkg::ST_SIDE:    state_in = dgr_pkg::ST_STEP;
         dgr_pkg::ST_STEP:    state_in = dgr_pkg::ST_TRD;
         dgr_pkg::ST_TRD:     state_in = dgr_pkg::ST_CHK;
         dgr_pkg::ST_CHK: begin
            if (status.hit) state_in = dgr_pkg::ST_MULP_I;
            else if (status.steps_done) state_in = dgr_pkg::ST_MISS;
            else state_in = dgr_pkg::ST_STEP;
         end
         dgr_pkg::ST_MULP_I:  state_in = dgr_pkg::ST_MULP;
         dgr_pkg::ST_MULP:    if (status.mul_last) state_in = dgr_pkg::ST_TRIG_C;
         dgr_pkg::ST_TRIG_C:  state_in = dgr_pkg::ST_MULD_I;
         dgr_pkg::ST_MULD_I:  state_in = dgr_pkg::ST_MULD;
         dgr_pkg::ST_MULD:    if (status.mul_last) state_in = dgr_pkg::ST_DSAT;
         dgr_pkg::ST_DSAT:    state_in = dgr_pkg::ST_DIVH;
         dgr_pkg::ST_DIVH:    state_in = dgr_pkg::ST_DIVH_W;
         dgr_pkg::ST_DIVH_W:  if (status.div_done) state_in = dgr_pkg::ST_HIT_OUT;
         default:             state_in = dgr_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      case (state_ff)
         dgr_pkg::ST_CLEAR:   cmd.op = dgr_pkg::OP_CLEAR;
         dgr_pkg::ST_IDLE:    cmd.op = start ? dgr_pkg::OP_LOAD : dgr_pkg::OP_IDLE;
         dgr_pkg::ST_TILE:    cmd.op = dgr_pkg::OP_TILE;
         dgr_pkg::ST_NOP:     cmd.op = dgr_pkg::OP_NOP;
         dgr_pkg::ST_DRD:     cmd.op = dgr_pkg::OP_DRD;
         dgr_pkg::ST_DOUT:    cmd.op = dgr_pkg::OP_DOUT;
         dgr_pkg::ST_ANGLE:   cmd.op = dgr_pkg::OP_ANGLE;
         dgr_pkg::ST_TRIG_X:  cmd.op = dgr_pkg::OP_TRIG_X;
         dgr_pkg::ST_TRIG_Y:  cmd.op = dgr_pkg::OP_TRIG_Y;
         dgr_pkg::ST_DIVX:    cmd.op = dgr_pkg::OP_DIV_X;
         dgr_pkg::ST_DIVX_W:  cmd.op = dgr_pkg::OP_WAIT_X;
         dgr_pkg::ST_DIVY:    cmd.op = dgr_pkg::OP_DIV_Y;
         dgr_pkg::ST_DIVY_W:  cmd.op = dgr_pkg::OP_WAIT_Y;
         dgr_pkg::ST_SIDE:    cmd.op = dgr_pkg::OP_SIDE;
         dgr_pkg::ST_STEP:    cmd.op = dgr_pkg::OP_STEP;
         dgr_pkg::ST_TRD:     cmd.op = dgr_pkg::OP_TRD;
         dgr_pkg::ST_CHK:     cmd.op = dgr_pkg::OP_CHK;
         dgr_pkg::ST_MISS:    cmd.op = dgr_pkg::OP_MISS;
         dgr_pkg::ST_MULP_I:  cmd.op = dgr_pkg::OP_MUL_INIT_P;
         dgr_pkg::ST_MULP:    cmd.op = dgr_pkg::OP_MUL;
         dgr_pkg::ST_TRIG_C:  cmd.op = dgr_pkg::OP_TRIG_C;
         dgr_pkg::ST_MULD_I:  cmd.op = dgr_pkg::OP_MUL_INIT_D;
         dgr_pkg::ST_MULD:    cmd.op = dgr_pkg::OP_MUL;
         dgr_pkg::ST_DSAT:    cmd.op = dgr_pkg::OP_DSAT;
         dgr_pkg::ST_DIVH:    cmd.op = dgr_pkg::OP_DIV_H;
         dgr_pkg::ST_DIVH_W:  cmd.op = dgr_pkg::OP_WAIT_H;
         dgr_pkg::ST_HIT_OUT: cmd.op = dgr_pkg::OP_HIT_OUT;
         default:             cmd.op = dgr_pkg::OP_IDLE;
      endcase
      busy = (state_ff != dgr_pkg::ST_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dgr_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

// ----- hdl/dgr_datapath.sv -----
`timescale 1ns / 1ps
module dgr_datapath #(
   parameter int MAP_SIZE_LOG2   = 6,
   parameter int MAX_COLUMNS     = 1024,
   parameter int MAX_STEPS       = 128,
   parameter int TRIG_TABLE_BITS = 10
) (
   input  logic                    clock,
   input  logic                    reset,
   input  dgr_pkg::dgr_cmd_type    cmd,
   output dgr_pkg::dgr_status_type status,
   input  logic [9:0]              req_column,
   input  logic [5:0]              req_tile_x,
   input  logic [5:0]              req_tile_y,
   input  logic [7:0]              req_tile_value,
   input  logic                    csr_we,
   input  logic [2:0]              csr_index,
   input  logic [23:0]             csr_wdata,
   output logic                    rsp_valid,
   output logic [9:0]              rsp_out_column,
   output logic [23:0]             rsp_distance,
   output logic [15:0]             rsp_wall_height,
   output logic signed [15:0]      rsp_wall_offset,
   output logic [7:0]              rsp_hit_tile,
   output logic                    rsp_hit_side,
   output logic [1:0]              rsp_color_code,
   output logic                    rsp_miss,
   output logic                    rsp_out_of_range
);
   localparam int TB      = TRIG_TABLE_BITS;
   localparam int TRIG_Q  = 1 << (TB - 2);
   localparam int MAP_N   = 1 << MAP_SIZE_LOG2;
   localparam int TILE_AW = 2 * MAP_SIZE_LOG2;
   localparam int TILE_N  = 1 << TILE_AW;
   localparam int COL_AW  = $clog2(MAX_COLUMNS);
   localparam int CLR_N   = (TILE_N > MAX_COLUMNS) ? TILE_N : MAX_COLUMNS;
   localparam int CLR_W   = $clog2(CLR_N);
   localparam int STEP_W  = $clog2(MAX_STEPS + 1);
   localparam int SIDE_W  = 31 + STEP_W;
   localparam int POS_W   = 12 + STEP_W;
   localparam int CH_W    = 24;
   localparam int NCH     = 3;
   localparam int ACC_W   = CH_W * NCH;
   localparam int MC_W    = $clog2(NCH);

   // configuration
   logic [15:0] cam_x_ff, cam_y_ff, cam_angle_ff;
   logic [14:0] fov_ff;
   logic [23:0] angle_step_ff;
   logic [10:0] screen_width_ff, tile_size_ff;
   logic [12:0] screen_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cam_x_ff         <= '0;
         cam_y_ff         <= '0;
         cam_angle_ff     <= '0;
         fov_ff           <= 15'd10923;
         angle_step_ff    <= 24'd2731;
         screen_width_ff  <= 11'd1024;
         screen_height_ff <= 13'd480;
         tile_size_ff     <= 11'd64;
      end else if (csr_we) begin
         case (csr_index)
            dgr_pkg::REG_CAM_X:         cam_x_ff         <= csr_wdata[15:0];
            dgr_pkg::REG_CAM_Y:         cam_y_ff         <= csr_wdata[15:0];
            dgr_pkg::REG_CAM_ANGLE:     cam_angle_ff     <= csr_wdata[15:0];
            dgr_pkg::REG_FOV:           fov_ff           <= csr_wdata[14:0];
            dgr_pkg::REG_ANGLE_STEP:    angle_step_ff    <= csr_wdata;
            dgr_pkg::REG_SCREEN_WIDTH:  screen_width_ff  <= csr_wdata[10:0];
            dgr_pkg::REG_SCREEN_HEIGHT: screen_height_ff <= csr_wdata[12:0];
            dgr_pkg::REG_TILE_SIZE:     tile_size_ff     <= csr_wdata[10:0];
            default: ;
         endcase
      end
   end

   // transaction registers
   logic [9:0] col_ff;
   logic [5:0] tx_ff, ty_ff;
   logic [7:0] tv_ff;

   always_ff @(posedge clock) begin
      if (cmd.op == dgr_pkg::OP_LOAD) begin
         col_ff <= req_column;
         tx_ff  <= req_tile_x;
         ty_ff  <= req_tile_y;
         tv_ff  <= req_tile_value;
      end
   end

   // trig table
   logic [14:0] qtab [TRIG_Q + 1];
   for (genvar g = 0; g <= TRIG_Q; g++) begin : g_qtab
      assign qtab[g] = dgr_pkg::quarter_sine(g, TB);
   end

   logic [15:0]        ray_ff;
   logic [15:0]        cdiff;
   logic [TB-1:0]      idx, cidx, trig_arg, kk;
   logic [1:0]         quad;
   logic [14:0]        trig_mag;
   logic signed [15:0] trig_val;
   logic [23:0]        ang_sum;

   always_comb begin
      ang_sum = {cam_angle_ff, 8'h00} - {2'b00, fov_ff, 7'h00}
                + 24'(col_ff * angle_step_ff);
      cdiff   = cam_angle_ff - ray_ff;
      idx     = ray_ff[15 -: TB];
      cidx    = cdiff[15 -: TB];
      case (cmd.op)
         dgr_pkg::OP_TRIG_X: trig_arg = idx + TB'(TRIG_Q);
         dgr_pkg::OP_TRIG_C: trig_arg = cidx + TB'(TRIG_Q);
         default:            trig_arg = idx;
      endcase
      quad     = trig_arg[TB-1 -: 2];
      kk       = quad[0] ? (TB'(TRIG_Q) - {2'b00, trig_arg[TB-3:0]})
                         : {2'b00, trig_arg[TB-3:0]};
      trig_mag = qtab[kk[TB-2:0]];
      trig_val = quad[1] ? -$signed({1'b0, trig_mag}) : $signed({1'b0, trig_mag});
   end

   // direction and divider
   logic signed [15:0] dx_ff, dy_ff, c_ff;
   logic [14:0]        adx, ady;
   logic [30:0]        ddx_ff, ddy_ff;
   logic [23:0]        d_ff;
   logic [15:0]        height_ff;
   logic               div_start, div_done;
   logic [31:0]        div_dividend, div_quot;
   logic [23:0]        div_divisor;

   always_comb begin
      adx          = dx_ff[15] ? 15'(-dx_ff) : dx_ff[14:0];
      ady          = dy_ff[15] ? 15'(-dy_ff) : dy_ff[14:0];
      div_start    = 1'b0;
      div_dividend = 32'h4000_0000;
      div_divisor  = {9'h000, adx};
      case (cmd.op)
         dgr_pkg::OP_DIV_X: div_start = 1'b1;
         dgr_pkg::OP_DIV_Y: begin
            div_start   = 1'b1;
            div_divisor = {9'h000, ady};
         end
         dgr_pkg::OP_WAIT_Y: div_divisor = {9'h000, ady};
         dgr_pkg::OP_DIV_H: begin
            div_start    = 1'b1;
            div_dividend = {24'(tile_size_ff) * 24'(screen_height_ff), 8'h00};
            div_divisor  = d_ff;
         end
         dgr_pkg::OP_WAIT_H: div_divisor = d_ff;
         default: ;
      endcase
   end

   dgr_div #(.N(32), .D(24)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quot)
   );

   // DDA walk
   logic [SIDE_W-1:0]       side_x_ff, side_y_ff, raw;
   logic signed [POS_W-1:0] mx_ff, my_ff;
   logic [STEP_W-1:0]       steps_ff;
   logic                    side_ff;
   logic                    go_x;
   logic [10:0]             fsel_x, fsel_y;
   logic [TILE_AW-1:0]      rd_addr;
   logic                    outside_ff;
   logic [7:0]              tile_rd_ff;
   logic [7:0]              hit_tile_ff;
   logic                    hit;

   always_comb begin
      go_x   = (dx_ff != '0) && ((dy_ff == '0) || (side_x_ff < side_y_ff));
      fsel_x = dx_ff[15] ? {1'b0, cam_x_ff[9:0]} : (11'd1024 - {1'b0, cam_x_ff[9:0]});
      fsel_y = dy_ff[15] ? {1'b0, cam_y_ff[9:0]} : (11'd1024 - {1'b0, cam_y_ff[9:0]});
      rd_addr = {my_ff[MAP_SIZE_LOG2-1:0], mx_ff[MAP_SIZE_LOG2-1:0]};
      hit     = outside_ff || (tile_rd_ff != 8'h00);
      raw     = side_ff ? (side_y_ff - SIDE_W'(ddy_ff)) : (side_x_ff - SIDE_W'(ddx_ff));
   end

   // chunked multiplier, top chunk first
   logic [ACC_W-1:0] ma_ff, acc_ff;
   logic [14:0]      mb_ff;
   logic [MC_W-1:0]  mcnt_ff;

   always_ff @(posedge clock) begin
      case (cmd.op)
         dgr_pkg::OP_ANGLE:  ray_ff <= ang_sum[23:8];
         dgr_pkg::OP_TRIG_X: dx_ff <= trig_val;
         dgr_pkg::OP_TRIG_Y: dy_ff <= trig_val;
         dgr_pkg::OP_TRIG_C: c_ff <= trig_val;
         dgr_pkg::OP_WAIT_X: if (div_done) ddx_ff <= (adx == '0) ? '0 : div_quot[30:0];
         dgr_pkg::OP_WAIT_Y: if (div_done) ddy_ff <= (ady == '0) ? '0 : div_quot[30:0];
         dgr_pkg::OP_SIDE: begin
            side_x_ff <= SIDE_W'((42'(fsel_x) * 42'(ddx_ff)) >> 10);
            side_y_ff <= SIDE_W'((42'(fsel_y) * 42'(ddy_ff)) >> 10);
            mx_ff     <= POS_W'(cam_x_ff[15:10]);
            my_ff     <= POS_W'(cam_y_ff[15:10]);
            steps_ff  <= '0;
         end
         dgr_pkg::OP_STEP: begin
            if (go_x) begin
               side_x_ff <= side_x_ff + SIDE_W'(ddx_ff);
               mx_ff     <= dx_ff[15] ? mx_ff - POS_W'(1) : mx_ff + POS_W'(1);
               side_ff   <= 1'b0;
            end else begin
               side_y_ff <= side_y_ff + SIDE_W'(ddy_ff);
               my_ff     <= dy_ff[15] ? my_ff - POS_W'(1) : my_ff + POS_W'(1);
               side_ff   <= 1'b1;
            end
            steps_ff <= steps_ff + 1'b1;
         end
         dgr_pkg::OP_CHK: hit_tile_ff <= outside_ff ? 8'd1 : tile_rd_ff;
         dgr_pkg::OP_MUL_INIT_P: begin
            ma_ff   <= ACC_W'(raw);
            mb_ff   <= {4'h0, tile_size_ff};
            acc_ff  <= '0;
            mcnt_ff <= '0;
         end
         dgr_pkg::OP_MUL_INIT_D: begin
            ma_ff   <= acc_ff;
            mb_ff   <= c_ff[14:0];
            acc_ff  <= '0;
            mcnt_ff <= '0;
         end
         dgr_pkg::OP_MUL: begin
            acc_ff  <= (acc_ff << CH_W) + ACC_W'(ma_ff[ACC_W-1 -: CH_W] * mb_ff);
            ma_ff   <= ma_ff << CH_W;
            mcnt_ff <= mcnt_ff + 1'b1;
         end
         dgr_pkg::OP_DSAT: begin
            if (c_ff[15] || (c_ff == '0)) d_ff <= '0;
            else if (acc_ff[ACC_W-1:46] != '0) d_ff <= dgr_pkg::DIST_MAX;
            else d_ff <= acc_ff[45:22];
         end
         dgr_pkg::OP_WAIT_H: begin
            if (div_done) begin
               if (d_ff == '0 || div_quot[31:16] != '0) height_ff <= 16'hFFFF;
               else height_ff <= div_quot[15:0];
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      outside_ff <= mx_ff < 0 || my_ff < 0 || mx_ff >= POS_W'(MAP_N)
                    || my_ff >= POS_W'(MAP_N);
   end

   // stores and clearing pass
   logic [7:0]         tile_mem  [TILE_N];
   logic [23:0]        depth_mem [MAX_COLUMNS];
   logic [CLR_W-1:0]   clr_ff;
   logic [11:0]        col_ext, tx_ext, ty_ext;
   logic               in_width, in_map;
   logic               tile_we, depth_we;
   logic [TILE_AW-1:0] tile_wa;
   logic [7:0]         tile_wd;
   logic [COL_AW-1:0]  depth_wa, depth_ra;
   logic [23:0]        depth_wd, depth_rd_ff;
   logic [23:0]        clr_ext;

   always_comb begin
      col_ext  = {2'b00, col_ff};
      tx_ext   = {6'h00, tx_ff};
      ty_ext   = {6'h00, ty_ff};
      clr_ext  = 24'(clr_ff);
      in_width = ({1'b0, col_ff} < screen_width_ff) && (32'(col_ff) < MAX_COLUMNS);
      in_map   = (32'(tx_ff) < MAP_N) && (32'(ty_ff) < MAP_N);
      depth_ra = col_ext[COL_AW-1:0];
      tile_we  = 1'b0;
      tile_wa  = {ty_ext[MAP_SIZE_LOG2-1:0], tx_ext[MAP_SIZE_LOG2-1:0]};
      tile_wd  = tv_ff;
      depth_we = 1'b0;
      depth_wa = col_ext[COL_AW-1:0];
      depth_wd = d_ff;
      case (cmd.op)
         dgr_pkg::OP_CLEAR: begin
            tile_we  = 32'(clr_ff) < TILE_N;
            tile_wa  = clr_ext[TILE_AW-1:0];
            tile_wd  = '0;
            depth_we = 32'(clr_ff) < MAX_COLUMNS;
            depth_wa = clr_ext[COL_AW-1:0];
            depth_wd = '0;
         end
         dgr_pkg::OP_TILE:    tile_we = in_map;
         dgr_pkg::OP_HIT_OUT: depth_we = in_width;
         dgr_pkg::OP_MISS: begin
            depth_we = in_width;
            depth_wd = dgr_pkg::DIST_MAX;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (tile_we) tile_mem[tile_wa] <= tile_wd;
      tile_rd_ff <= tile_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (depth_we) depth_mem[depth_wa] <= depth_wd;
      depth_rd_ff <= depth_mem[depth_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.op == dgr_pkg::OP_CLEAR) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   // result register
   logic        rsp_valid_ff;
   logic [9:0]  o_col_ff;
   logic [23:0] o_dist_ff;
   logic [15:0] o_height_ff;
   logic [15:0] o_offset_ff;
   logic [7:0]  o_tile_ff;
   logic        o_side_ff, o_miss_ff, o_oor_ff;
   logic [1:0]  o_color_ff;
   logic        emit;

   always_comb begin
      case (cmd.op)
         dgr_pkg::OP_TILE, dgr_pkg::OP_NOP, dgr_pkg::OP_DOUT,
         dgr_pkg::OP_MISS, dgr_pkg::OP_HIT_OUT: emit = 1'b1;
         default: emit = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= emit;
      end
      if (emit) begin
         o_col_ff    <= col_ff;
         o_dist_ff   <= '0;
         o_height_ff <= '0;
         o_offset_ff <= '0;
         o_tile_ff   <= '0;
         o_side_ff   <= 1'b0;
         o_color_ff  <= '0;
         o_miss_ff   <= 1'b0;
         o_oor_ff    <= 1'b0;
         case (cmd.op)
            dgr_pkg::OP_DOUT: begin
               o_dist_ff <= in_width ? depth_rd_ff : dgr_pkg::DIST_MAX;
               o_oor_ff  <= !in_width;
            end
            dgr_pkg::OP_MISS: begin
               o_dist_ff   <= dgr_pkg::DIST_MAX;
               o_offset_ff <= {4'h0, screen_height_ff[12:1]};
               o_miss_ff   <= 1'b1;
            end
            dgr_pkg::OP_HIT_OUT: begin
               o_dist_ff   <= d_ff;
               o_height_ff <= height_ff;
               o_offset_ff <= {4'h0, screen_height_ff[12:1]} - {1'b0, height_ff[15:1]};
               o_tile_ff   <= hit_tile_ff;
               o_side_ff   <= side_ff;
               o_color_ff  <= (hit_tile_ff == 8'd2) ? 2'd0 : (side_ff ? 2'd2 : 2'd1);
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      status.clr_last   = (32'(clr_ff) == CLR_N - 1);
      status.div_done   = div_done;
      status.hit        = hit;
      status.steps_done = (32'(steps_ff) == MAX_STEPS);
      status.mul_last   = (32'(mcnt_ff) == NCH - 1);
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_column   = o_col_ff;
   assign rsp_distance     = o_dist_ff;
   assign rsp_wall_height  = o_height_ff;
   assign rsp_wall_offset  = $signed(o_offset_ff);
   assign rsp_hit_tile     = o_tile_ff;
   assign rsp_hit_side     = o_side_ff;
   assign rsp_color_code   = o_color_ff;
   assign rsp_miss         = o_miss_ff;
   assign rsp_out_of_range = o_oor_ff;
endmodule

// ----- hdl/dda_grid_raycaster_core.sv -----
`timescale 1ns / 1ps
// Grid raycaster over a stored tile map.
// Commands enter on req_*: a transaction is taken when start is high and busy
// is low. Command 0 writes one map cell, 1 casts the ray of one column, 2
// reads the depth recorded for a column; any other code returns an empty
// result. Each transaction gives exactly one result on rsp_*, marked by a
// one-cycle rsp_valid strobe; the receiver cannot stall it.
// Camera and screen settings are written through csr_we/csr_index/csr_wdata.
// The user must write them only while busy is low: not enforced by the core.
// A cast runs the shared 32-step divider twice for the DDA deltas and, on a
// hit, once more for the wall height; a ray that meets no wall within
// MAX_STEPS cells is a miss. Each DDA step loops through the step, tile read
// and check states around the registered tile memory read, and the 72-bit
// products run in three 24-bit chunks. One transaction is in flight at a time.
// After reset a clearing pass zeroes both stores, one entry a cycle, over
// max(4^MAP_SIZE_LOG2, MAX_COLUMNS) addresses (4096 by default); busy is high
// throughout and configuration writes are still taken.
module dda_grid_raycaster_core #(
   parameter int MAP_SIZE_LOG2   = 6,
   parameter int MAX_COLUMNS     = 1024,
   parameter int MAX_STEPS       = 128,
   parameter int TRIG_TABLE_BITS = 10
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_command,
   input  logic [9:0]         req_column,
   input  logic [5:0]         req_tile_x,
   input  logic [5:0]         req_tile_y,
   input  logic [7:0]         req_tile_value,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [23:0]        csr_wdata,
   output logic               rsp_valid,
   output logic [9:0]         rsp_out_column,
   output logic [23:0]        rsp_distance,
   output logic [15:0]        rsp_wall_height,
   output logic signed [15:0] rsp_wall_offset,
   output logic [7:0]         rsp_hit_tile,
   output logic               rsp_hit_side,
   output logic [1:0]         rsp_color_code,
   output logic               rsp_miss,
   output logic               rsp_out_of_range
);
   dgr_pkg::dgr_cmd_type    cmd;
   dgr_pkg::dgr_status_type status;

   dgr_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_command (req_command),
      .status      (status),
      .cmd         (cmd),
      .busy        (busy)
   );

   dgr_datapath #(
      .MAP_SIZE_LOG2   (MAP_SIZE_LOG2),
      .MAX_COLUMNS     (MAX_COLUMNS),
      .MAX_STEPS       (MAX_STEPS),
      .TRIG_TABLE_BITS (TRIG_TABLE_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_column       (req_column),
      .req_tile_x       (req_tile_x),
      .req_tile_y       (req_tile_y),
      .req_tile_value   (req_tile_value),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_valid        (rsp_valid),
      .rsp_out_column   (rsp_out_column),
      .rsp_distance     (rsp_distance),
      .rsp_wall_height  (rsp_wall_height),
      .rsp_wall_offset  (rsp_wall_offset),
      .rsp_hit_tile     (rsp_hit_tile),
      .rsp_hit_side     (rsp_hit_side),
      .rsp_color_code   (rsp_color_code),
      .rsp_miss         (rsp_miss),
      .rsp_out_of_range (rsp_out_of_range)
   );
endmodule

// ----- tb/dda_grid_raycaster_checker.sv -----
`timescale 1ns / 1ps
module dda_grid_raycaster_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic [1:0]         req_command,
   input  logic [9:0]         req_column,
   input  logic [5:0]         req_tile_x,
   input  logic [5:0]         req_tile_y,
   input  logic [7:0]         req_tile_value,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [23:0]        csr_wdata,
   input  logic               rsp_valid,
   input  logic [9:0]         rsp_out_column,
   input  logic [23:0]        rsp_distance,
   input  logic [15:0]        rsp_wall_height,
   input  logic signed [15:0] rsp_wall_offset,
   input  logic [7:0]         rsp_hit_tile,
   input  logic               rsp_hit_side,
   input  logic [1:0]         rsp_color_code,
   input  logic               rsp_miss,
   input  logic               rsp_out_of_range,
   output int                 errors,
   output int                 pending
);

   typedef struct {
      logic [9:0]  column;
      logic [23:0] distance;
      logic [15:0] height;
      logic [15:0] offset;
      logic [7:0]  tile;
      logic        side;
      logic [1:0]  color;
      logic        miss;
      logic        oor;
   } column_result_type;

   logic [7:0]  tile_map [4096];
   logic [23:0] depth_mem [1024];
   logic [15:0] cam_x, cam_y, cam_angle;
   logic [14:0] fov;
   logic [23:0] angle_step;
   logic [10:0] screen_width, tile_size;
   logic [12:0] screen_height;
   column_result_type expected_q [$];

   assign pending = expected_q.size();

   function automatic longint quarter_wave(longint k);
      longint t, x2, acc, r, q;
      if (k >= 256) begin
         return 16384;
      end
      t   = k * 256;
      x2  = (t * t) / 65536;
      acc = 2692;
      acc = -78547 + (acc * x2) / 65536;
      acc = 1337020 + (acc * x2) / 65536;
      acc = -10837479 + (acc * x2) / 65536;
      acc = 26353589 + (acc * x2) / 65536;
      r   = (acc * t) / 65536;
      if (r < 0) begin
         r = 0;
      end
      q = (r + 512) / 1024;
      return (q > 16384) ? 16384 : q;
   endfunction

   function automatic longint trig_lookup(longint i);
      longint quad, k, v;
      i    = i & 1023;
      quad = i / 256;
      k    = i % 256;
      v    = quad[0] ? quarter_wave(256 - k) : quarter_wave(k);
      return (quad >= 2) ? -v : v;
   endfunction

   function automatic longint map_cell(longint x, longint y);
      if (x < 0 || y < 0 || x >= 64 || y >= 64) begin
         return 1;
      end
      return tile_map[y * 64 + x];
   endfunction

   function automatic column_result_type cast_ray(logic [9:0] col);
      column_result_type res;
      longint ray, dx, dy, ddx, ddy, mx, my, fx, fy, sx, sy, side_x, side_y;
      longint tile, side, raw, p, c, d, num, height;
      res        = '{default: '0};
      res.column = col;
      ray = (((longint'(cam_angle) << 8) - (longint'(fov) << 7)
             + longint'(col) * longint'(angle_step)) & 64'hFFFFFF) >> 8;
      dx  = trig_lookup((ray >> 6) + 256);
      dy  = trig_lookup(ray >> 6);
      ddx = (dx != 0) ? (longint'(1) << 30) / ((dx < 0) ? -dx : dx) : 0;
      ddy = (dy != 0) ? (longint'(1) << 30) / ((dy < 0) ? -dy : dy) : 0;
      mx  = cam_x >> 10;
      my  = cam_y >> 10;
      fx  = cam_x & 1023;
      fy  = cam_y & 1023;
      sx  = (dx < 0) ? -1 : 1;
      sy  = (dy < 0) ? -1 : 1;
      side_x = (((dx < 0) ? fx : 1024 - fx) * ddx) >> 10;
      side_y = (((dy < 0) ? fy : 1024 - fy) * ddy) >> 10;
      tile = 0;
      side = 0;
      for (int n = 0; n < 128; n++) begin
         if (dx != 0 && (dy == 0 || side_x < side_y)) begin
            side_x += ddx;
            mx += sx;
            side = 0;
         end else begin
            side_y += ddy;
            my += sy;
            side = 1;
         end
         tile = map_cell(mx, my);
         if (tile != 0) begin
            break;
         end
      end
      if (tile == 0) begin
         d            = 24'hFFFFFF;
         res.distance = dgr_pkg::DIST_MAX;
         res.offset   = 16'(screen_height >> 1);
         res.miss     = 1'b1;
      end else begin
         raw = side ? side_y - ddy : side_x - ddx;
         p   = raw * tile_size;
         c   = trig_lookup(((longint'(cam_angle) - ray) & 16'hFFFF) / 64 + 256);
         if (c <= 0) begin
            d = 0;
         end else begin
            d = (p >> 22) * c + (((p & 64'h3FFFFF) * c) >> 22);
            if (d > 24'hFFFFFF) begin
               d = 24'hFFFFFF;
            end
         end
         num    = (longint'(tile_size) * screen_height) << 8;
         height = (d == 0) ? 65535 : num / d;
         if (height > 65535) begin
            height = 65535;
         end
         res.distance = 24'(d);
         res.height   = 16'(height);
         res.offset   = 16'(longint'(screen_height >> 1) - (height >> 1));
         res.tile     = 8'(tile);
         res.side     = side[0];
         res.color    = (tile == 2) ? 2'd0 : (side == 0) ? 2'd1 : 2'd2;
      end
      if (col < screen_width) begin
         depth_mem[col] = 24'(d);
      end
      return res;
   endfunction

   function automatic column_result_type predict_result();
      column_result_type res;
      res        = '{default: '0};
      res.column = req_column;
      case (req_command)
         dgr_pkg::CMD_WRITE_TILE: tile_map[{req_tile_y, req_tile_x}] = req_tile_value;
         dgr_pkg::CMD_CAST:       res = cast_ray(req_column);
         dgr_pkg::CMD_READ_DEPTH: begin
            if (req_column < screen_width) begin
               res.distance = depth_mem[req_column];
            end else begin
               res.distance = dgr_pkg::DIST_MAX;
               res.oor      = 1'b1;
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   task automatic check_field(string name, longint want, longint got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         errors++;
      end
   endtask

   initial errors = 0;

   always @(posedge clock) begin
      column_result_type want;
      if (reset) begin
         foreach (tile_map[i]) tile_map[i] = '0;
         foreach (depth_mem[i]) depth_mem[i] = '0;
         cam_x         = '0;
         cam_y         = '0;
         cam_angle     = '0;
         fov           = 15'd10923;
         angle_step    = 24'd2731;
         screen_width  = 11'd1024;
         screen_height = 13'd480;
         tile_size     = 11'd64;
         expected_q.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected transaction, column %0d", $time, rsp_out_column);
               errors++;
            end else begin
               want = expected_q.pop_front();
               check_field("out_column", want.column, rsp_out_column);
               check_field("distance", want.distance, rsp_distance);
               check_field("wall_height", want.height, rsp_wall_height);
               check_field("wall_offset", want.offset, $unsigned(rsp_wall_offset));
               check_field("hit_tile", want.tile, rsp_hit_tile);
               check_field("hit_side", want.side, rsp_hit_side);
               check_field("color_code", want.color, rsp_color_code);
               check_field("miss", want.miss, rsp_miss);
               check_field("out_of_range", want.oor, rsp_out_of_range);
            end
         end
         if (csr_we) begin
            case (csr_index)
               dgr_pkg::REG_CAM_X:         cam_x = csr_wdata[15:0];
               dgr_pkg::REG_CAM_Y:         cam_y = csr_wdata[15:0];
               dgr_pkg::REG_CAM_ANGLE:     cam_angle = csr_wdata[15:0];
               dgr_pkg::REG_FOV:           fov = csr_wdata[14:0];
               dgr_pkg::REG_ANGLE_STEP:    angle_step = csr_wdata;
               dgr_pkg::REG_SCREEN_WIDTH:  screen_width = csr_wdata[10:0];
               dgr_pkg::REG_SCREEN_HEIGHT: screen_height = csr_wdata[12:0];
               dgr_pkg::REG_TILE_SIZE:     tile_size = csr_wdata[10:0];
               default: ;
            endcase
         end
         if (start && !busy) begin
            expected_q.push_back(predict_result());
         end
      end
   end

endmodule

// ----- tb/tb_dda_grid_raycaster_core.sv -----
`timescale 1ns / 1ps
module tb_dda_grid_raycaster_core;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [1:0]         req_command = '0;
   logic [9:0]         req_column = '0;
   logic [5:0]         req_tile_x = '0;
   logic [5:0]         req_tile_y = '0;
   logic [7:0]         req_tile_value = '0;
   logic               csr_we = 1'b0;
   logic [2:0]         csr_index = '0;
   logic [23:0]        csr_wdata = '0;
   logic               rsp_valid;
   logic [9:0]         rsp_out_column;
   logic [23:0]        rsp_distance;
   logic [15:0]        rsp_wall_height;
   logic signed [15:0] rsp_wall_offset;
   logic [7:0]         rsp_hit_tile;
   logic               rsp_hit_side;
   logic [1:0]         rsp_color_code;
   logic               rsp_miss;
   logic               rsp_out_of_range;
   int                 errors;
   int                 pending;
   int                 width_now;

   always #5 clock = ~clock;

   dda_grid_raycaster_core DUT (.*);
   dda_grid_raycaster_checker u_checker (.*);

   task automatic send_cmd(logic [1:0] cmd, logic [9:0] col, logic [5:0] tx,
                           logic [5:0] ty, logic [7:0] tv);
      int gap;
      int pick;
      @(posedge clock);
      start          <= 1'b1;
      req_command    <= cmd;
      req_column     <= col;
      req_tile_x     <= tx;
      req_tile_y     <= ty;
      req_tile_value <= tv;
      do @(negedge clock); while (busy);
      @(posedge clock);
      pick = $urandom_range(99);
      gap  = (pick < 40) ? 0 : (pick < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap - 1) @(posedge clock);
      end else begin
         // hold start; next call drives at the following edge
         start <= 1'b1;
      end
   endtask

   task automatic wait_quiet();
      @(posedge clock);
      start <= 1'b0;
      do @(negedge clock); while (busy || pending != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [23:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_phase(int ph);
      logic [15:0] cx, cy;
      logic [23:0] w, h, ts, fv, stp;
      cx  = (ph == 1) ? 16'd0 : (ph == 2) ? 16'hFFFF : 16'($urandom);
      cy  = (ph == 1) ? 16'd0 : (ph == 2) ? 16'hFFFF : 16'($urandom);
      if (ph == 7) begin
         cx[9:0] = '0;
         cy[9:0] = '0;
      end
      fv  = 24'((ph == 3) ? 0 : (ph == 4) ? 32767 : $urandom_range(32767));
      stp = 24'((ph == 3) ? 0 : (ph == 4) ? 24'hFFFFFF : $urandom_range(20000));
      w   = 24'((ph == 5) ? 1 : (ph == 6) ? 1024 : $urandom_range(1, 1024));
      h   = 24'((ph == 5) ? 1 : (ph == 6) ? 4096 : $urandom_range(1, 4096));
      ts  = 24'((ph == 5) ? 1 : (ph == 6) ? 1024 : $urandom_range(1, 1024));
      write_reg(dgr_pkg::REG_CAM_X, {8'h00, cx});
      write_reg(dgr_pkg::REG_CAM_Y, {8'h00, cy});
      write_reg(dgr_pkg::REG_CAM_ANGLE,
                (ph == 1) ? 24'd0 : (ph == 2) ? 24'hFFFF : 24'($urandom_range(65535)));
      write_reg(dgr_pkg::REG_FOV, fv);
      write_reg(dgr_pkg::REG_ANGLE_STEP, stp);
      write_reg(dgr_pkg::REG_SCREEN_WIDTH, w);
      write_reg(dgr_pkg::REG_SCREEN_HEIGHT, h);
      write_reg(dgr_pkg::REG_TILE_SIZE, ts);
      width_now = int'(w);
   endtask

   task automatic random_item();
      int pick;
      logic [9:0] col;
      pick = $urandom_range(99);
      col  = ($urandom_range(3) == 0) ? 10'($urandom) : 10'($urandom_range(width_now - 1));
      if (pick < 35) begin
         send_cmd(dgr_pkg::CMD_WRITE_TILE, 10'($urandom), 6'($urandom), 6'($urandom),
                  ($urandom_range(99) < 60) ? 8'd0 : 8'($urandom));
      end else if (pick < 80) begin
         send_cmd(dgr_pkg::CMD_CAST, col, 6'($urandom), 6'($urandom), 8'($urandom));
      end else if (pick < 95) begin
         send_cmd(dgr_pkg::CMD_READ_DEPTH, col, 6'($urandom), 6'($urandom), 8'($urandom));
      end else begin
         send_cmd(dgr_pkg::CMD_UNUSED, 10'($urandom), 6'($urandom), 6'($urandom),
                  8'($urandom));
      end
   endtask

   initial begin
      width_now = 1024;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      do @(negedge clock); while (busy);

      send_cmd(dgr_pkg::CMD_READ_DEPTH, 10'd5, 6'd0, 6'd0, 8'd0);
      send_cmd(dgr_pkg::CMD_WRITE_TILE, 10'd0, 6'd5, 6'd0, 8'd2);
      send_cmd(dgr_pkg::CMD_WRITE_TILE, 10'd1023, 6'd0, 6'd5, 8'd255);
      send_cmd(dgr_pkg::CMD_WRITE_TILE, 10'd0, 6'd63, 6'd63, 8'd1);
      send_cmd(dgr_pkg::CMD_WRITE_TILE, 10'd0, 6'd3, 6'd3, 8'd7);
      send_cmd(dgr_pkg::CMD_CAST, 10'd0, 6'd0, 6'd0, 8'd0);
      send_cmd(dgr_pkg::CMD_CAST, 10'd512, 6'd0, 6'd0, 8'd0);
      send_cmd(dgr_pkg::CMD_CAST, 10'd1023, 6'h3F, 6'h3F, 8'hFF);
      send_cmd(dgr_pkg::CMD_READ_DEPTH, 10'd0, 6'd0, 6'd0, 8'd0);
      send_cmd(dgr_pkg::CMD_READ_DEPTH, 10'd1023, 6'd0, 6'd0, 8'd0);
      send_cmd(dgr_pkg::CMD_UNUSED, 10'd1023, 6'h3F, 6'h3F, 8'hFF);
      wait_quiet();
      // camera on a cell corner next to walls: zero distance
      write_reg(dgr_pkg::REG_CAM_X, 24'h0C00);
      write_reg(dgr_pkg::REG_CAM_Y, 24'h0C00);
      write_reg(dgr_pkg::REG_CAM_ANGLE, 24'h8000);
      write_reg(dgr_pkg::REG_SCREEN_WIDTH, 24'd16);
      width_now = 16;
      send_cmd(dgr_pkg::CMD_WRITE_TILE, 10'd0, 6'd2, 6'd3, 8'd2);
      send_cmd(dgr_pkg::CMD_CAST, 10'd4, 6'd0, 6'd0, 8'd0);
      send_cmd(dgr_pkg::CMD_CAST, 10'd900, 6'd0, 6'd0, 8'd0);
      send_cmd(dgr_pkg::CMD_READ_DEPTH, 10'd4, 6'd0, 6'd0, 8'd0);
      send_cmd(dgr_pkg::CMD_READ_DEPTH, 10'd900, 6'd0, 6'd0, 8'd0);
      wait_quiet();
      write_reg(dgr_pkg::REG_FOV, 24'd32767);
      write_reg(dgr_pkg::REG_ANGLE_STEP, 24'd8192);
      // rays about a right angle from the view direction: cosine at or near zero
      send_cmd(dgr_pkg::CMD_CAST, 10'd0, 6'd0, 6'd0, 8'd0);
      send_cmd(dgr_pkg::CMD_CAST, 10'd6, 6'd0, 6'd0, 8'd0);
      send_cmd(dgr_pkg::CMD_CAST, 10'd15, 6'd0, 6'd0, 8'd0);
      wait_quiet();

      for (int ph = 0; ph < 8; ph++) begin
         set_phase(ph);
         repeat (75) random_item();
         wait_quiet();
      end

      repeat (50) @(negedge clock);
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
